// File: rtl/core/tprq_pkg.sv
// ----------------------------------------------------------------------------
// tprq_pkg
// shared types, codes and constants of the task priority ready queue
// ----------------------------------------------------------------------------
package tprq_pkg;

  localparam int unsigned TaskBits     = 7;
  localparam int unsigned PrioBits     = 8;
  localparam int unsigned CountBits    = 6;
  localparam int unsigned DefaultDepth = 32;

  typedef enum logic [1:0] {
    ACT_PUT  = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PULL = 2'd2,
    ACT_NEXT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [TaskBits-1:0] task_id;
    logic [PrioBits-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [TaskBits-1:0]  result_task;
    logic [1:0]           status;
    logic [CountBits-1:0] count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT_WALK,
    ST_PUT_FIN,
    ST_POP,
    ST_NEXT_CAP,
    ST_PULL_SCAN,
    ST_PULL_SHIFT,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    RD_TOP,
    RD_ZERO,
    RD_POS_M1,
    RD_POS_M2,
    RD_POS_P1,
    RD_POS_P2
  } rd_sel_e;

  typedef enum logic {
    WR_RDATA,
    WR_HOLD
  } wr_src_e;

  typedef enum logic [2:0] {
    POS_KEEP,
    POS_LD_OCC,
    POS_LD_TOP,
    POS_LD_ZERO,
    POS_DEC,
    POS_INC
  } pos_op_e;

  typedef enum logic [1:0] {
    OCC_KEEP,
    OCC_INC,
    OCC_DEC
  } occ_op_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RDATA,
    RES_HOLD
  } res_src_e;

  typedef struct packed {
    rd_sel_e  rd_sel;
    logic     mem_we;
    wr_src_e  wr_src;
    pos_op_e  pos_op;
    occ_op_e  occ_op;
    logic     hold_ld_in;
    logic     hold_ld_rd;
    logic     res_ld;
    res_src_e res_src;
    status_e  res_status;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic occ_full;
    logic pos_zero;
    logic pos_one;
    logic prio_ge;
    logic task_match;
    logic scan_last;
    logic shift_more;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/tprq_datapath.sv
// ----------------------------------------------------------------------------
// tprq_datapath
// sorted slot store, walk pointer, occupancy and result register
// ----------------------------------------------------------------------------
module tprq_datapath #(
  parameter int unsigned DEPTH = tprq_pkg::DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tprq_pkg::req_t      in_i,
  input  tprq_pkg::dp_cmd_t   cmd_i,
  output tprq_pkg::dp_status_t stat_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output tprq_pkg::rsp_t      out_o
);
  import tprq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned EntW = TaskBits + PrioBits;

  logic [EntW-1:0]     mem_q [DEPTH];
  logic [EntW-1:0]     rdata_q;
  logic [EntW-1:0]     wdata;
  logic [CntW-1:0]     rd_ptr;
  logic [CntW-1:0]     occ_q, occ_d;
  logic [CntW-1:0]     pos_q, pos_d;
  logic [TaskBits-1:0] hold_task_q, hold_task_d;
  logic [PrioBits-1:0] hold_prio_q, hold_prio_d;
  logic [TaskBits-1:0] res_task_q, res_task_d;
  status_e             res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_q, out_d;
  logic [TaskBits-1:0] rd_task;
  logic [PrioBits-1:0] rd_prio;

  assign rd_task = rdata_q[EntW-1:PrioBits];
  assign rd_prio = rdata_q[PrioBits-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      RD_TOP:    rd_ptr = occ_q - CntW'(1);
      RD_ZERO:   rd_ptr = '0;
      RD_POS_M1: rd_ptr = pos_q - CntW'(1);
      RD_POS_M2: rd_ptr = pos_q - CntW'(2);
      RD_POS_P1: rd_ptr = pos_q + CntW'(1);
      RD_POS_P2: rd_ptr = pos_q + CntW'(2);
      default:   rd_ptr = '0;
    endcase
  end

  assign wdata = (cmd_i.wr_src == WR_RDATA) ? rdata_q : {hold_task_q, hold_prio_q};

  // single write port at the walk pointer, registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_ptr[AW-1:0]];
    if (cmd_i.mem_we) begin
      mem_q[pos_q[AW-1:0]] <= wdata;
    end
  end

  always_comb begin
    case (cmd_i.pos_op)
      POS_LD_OCC:  pos_d = occ_q;
      POS_LD_TOP:  pos_d = occ_q - CntW'(1);
      POS_LD_ZERO: pos_d = '0;
      POS_DEC:     pos_d = pos_q - CntW'(1);
      POS_INC:     pos_d = pos_q + CntW'(1);
      default:     pos_d = pos_q;
    endcase
  end

  always_comb begin
    case (cmd_i.occ_op)
      OCC_INC: occ_d = occ_q + CntW'(1);
      OCC_DEC: occ_d = occ_q - CntW'(1);
      default: occ_d = occ_q;
    endcase
  end

  always_comb begin
    hold_task_d = hold_task_q;
    hold_prio_d = hold_prio_q;
    if (cmd_i.hold_ld_in) begin
      hold_task_d = in_i.task_id;
      hold_prio_d = in_i.priority_req;
    end else if (cmd_i.hold_ld_rd) begin
      hold_task_d = rd_task;
      hold_prio_d = rd_prio;
    end
  end

  always_comb begin
    res_task_d   = res_task_q;
    res_status_d = res_status_q;
    if (cmd_i.res_ld) begin
      res_status_d = cmd_i.res_status;
      case (cmd_i.res_src)
        RES_RDATA: res_task_d = rd_task;
        RES_HOLD:  res_task_d = hold_task_q;
        default:   res_task_d = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_ld) begin
      out_valid_d       = 1'b1;
      out_d.result_task = res_task_q;
      out_d.status      = res_status_q;
      out_d.count       = CountBits'(occ_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_task_q  <= hold_task_d;
    hold_prio_q  <= hold_prio_d;
    res_task_q   <= res_task_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  assign stat_o.occ_zero   = (occ_q == '0);
  assign stat_o.occ_full   = (occ_q == CntW'(DEPTH));
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.pos_one    = (pos_q == CntW'(1));
  assign stat_o.prio_ge    = (rd_prio >= hold_prio_q);
  assign stat_o.task_match = (rd_task == hold_task_q);
  assign stat_o.scan_last  = ((pos_q + CntW'(1)) == occ_q);
  assign stat_o.shift_more = (pos_q < occ_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/core/tprq_ctrl.sv
// ----------------------------------------------------------------------------
// tprq_ctrl
// sequencer for put, pop, pull and next over the sorted store
// ----------------------------------------------------------------------------
module tprq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           action_i,
  output logic                 in_ready_o,
  input  tprq_pkg::dp_status_t stat_i,
  output tprq_pkg::dp_cmd_t    cmd_o
);
  import tprq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_PUT: begin
              if (stat_i.occ_full)      state_d = ST_DONE;
              else if (stat_i.occ_zero) state_d = ST_PUT_FIN;
              else                      state_d = ST_PUT_WALK;
            end
            ACT_POP:  state_d = stat_i.occ_zero ? ST_DONE : ST_POP;
            ACT_PULL: state_d = stat_i.occ_zero ? ST_DONE : ST_PULL_SCAN;
            default:  state_d = stat_i.occ_zero ? ST_DONE : ST_NEXT_CAP;
          endcase
        end
      end
      ST_PUT_WALK: begin
        if (!stat_i.prio_ge)    state_d = ST_DONE;
        else if (stat_i.pos_one) state_d = ST_PUT_FIN;
      end
      ST_PUT_FIN:  state_d = ST_DONE;
      ST_POP:      state_d = ST_DONE;
      ST_NEXT_CAP: state_d = stat_i.pos_zero ? ST_PUT_FIN : ST_PUT_WALK;
      ST_PULL_SCAN: begin
        if (stat_i.task_match)     state_d = ST_PULL_SHIFT;
        else if (stat_i.scan_last) state_d = ST_DONE;
      end
      ST_PULL_SHIFT: begin
        if (!stat_i.shift_more) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.rd_sel     = RD_TOP;
    cmd_o.wr_src     = WR_HOLD;
    cmd_o.pos_op     = POS_KEEP;
    cmd_o.occ_op     = OCC_KEEP;
    cmd_o.res_src    = RES_ZERO;
    cmd_o.res_status = STAT_OK;
    case (state_q)
      ST_IDLE: begin
        cmd_o.rd_sel = (action_i == ACT_PULL) ? RD_ZERO : RD_TOP;
        if (accept) begin
          cmd_o.res_ld = 1'b1;
          case (action_i)
            ACT_PUT: begin
              if (stat_i.occ_full) begin
                cmd_o.res_status = STAT_FULL;
              end else begin
                cmd_o.hold_ld_in = 1'b1;
                cmd_o.pos_op     = POS_LD_OCC;
                cmd_o.occ_op     = OCC_INC;
              end
            end
            ACT_POP: begin
              cmd_o.res_ld = stat_i.occ_zero;
              cmd_o.res_status = STAT_EMPTY;
            end
            ACT_PULL: begin
              cmd_o.hold_ld_in = 1'b1;
              cmd_o.pos_op     = POS_LD_ZERO;
              cmd_o.res_ld     = stat_i.occ_zero;
              cmd_o.res_status = STAT_NOT_FOUND;
            end
            default: begin
              cmd_o.pos_op     = POS_LD_TOP;
              cmd_o.res_ld     = stat_i.occ_zero;
              cmd_o.res_status = STAT_EMPTY;
            end
          endcase
        end
      end
      ST_PUT_WALK: begin
        cmd_o.rd_sel = RD_POS_M2;
        cmd_o.mem_we = 1'b1;
        if (stat_i.prio_ge) begin
          cmd_o.wr_src = WR_RDATA;
          cmd_o.pos_op = POS_DEC;
        end
      end
      ST_PUT_FIN: begin
        cmd_o.mem_we = 1'b1;
      end
      ST_POP: begin
        cmd_o.res_ld  = 1'b1;
        cmd_o.res_src = RES_RDATA;
        cmd_o.occ_op  = OCC_DEC;
      end
      ST_NEXT_CAP: begin
        cmd_o.rd_sel     = RD_POS_M1;
        cmd_o.hold_ld_rd = 1'b1;
        cmd_o.res_ld     = 1'b1;
        cmd_o.res_src    = RES_RDATA;
      end
      ST_PULL_SCAN: begin
        cmd_o.rd_sel = RD_POS_P1;
        if (stat_i.task_match) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_src = RES_HOLD;
          cmd_o.occ_op  = OCC_DEC;
        end else if (stat_i.scan_last) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = STAT_NOT_FOUND;
        end else begin
          cmd_o.pos_op = POS_INC;
        end
      end
      ST_PULL_SHIFT: begin
        cmd_o.rd_sel = RD_POS_P2;
        if (stat_i.shift_more) begin
          cmd_o.mem_we = 1'b1;
          cmd_o.wr_src = WR_RDATA;
          cmd_o.pos_op = POS_INC;
        end
      end
      ST_DONE: begin
        cmd_o.out_ld = stat_i.out_free;
      end
      default: begin
        cmd_o.out_ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/task_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// task_priority_ready_queue
// sorted ready queue of task ids with put, pop, pull and round-robin next
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH task ids sorted by priority in one memory with
// a write port and a registered read port, and serves one request at a time:
// a request is taken only while the sequencer is idle, and its single result
// lands in an output register, so a result still waiting to be taken does not
// stop the next request from being taken. That next result is held back until
// the output register frees up. Pop reads the top entry; put and next move
// entries one by one to open the slot, and pull scans to the named task and
// then walks the entries above it down to close the gap, or ends after the
// scan when the task is not found. The walk over the memory moves one entry
// per cycle through its single write port. A put on a full queue and the
// empty and not found cases on an empty queue finish without a walk. The
// memory needs no clearing after reset, since only slots below the occupancy
// are ever used.
module task_priority_ready_queue #(
  parameter int unsigned DEPTH = tprq_pkg::DefaultDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tprq_pkg::req_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tprq_pkg::rsp_t out_o
);
  import tprq_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t stat;

  // sequencer: decodes the request action and steps through the walk
  tprq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_i.action),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // sorted store, pointers and the output register
  tprq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the task priority ready queue
// ----------------------------------------------------------------------------
// Requests are driven through the valid/ready input channel by one send task.
// A shadow copy of the sorted queue is updated at each accepted request and
// gives the expected response. A monitor compares every accepted response,
// field by field, against the oldest expected response. The tests run in
// turn: directed corner cases, fill to overflow and drain, a long output
// hold-off that backs up the input, then random phases with changing mix,
// priority spread, sender bursts and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tprq_pkg::*;

  localparam int Depth       = DefaultDepth;
  localparam int TimeoutNs   = 10_000_000;
  localparam int DrainLimit  = 20_000;
  localparam int HoldCycles  = 400;
  localparam int RandomItems = 1500;

  // dut ports
  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_o;

  // shadow of the sorted queue, slot 0 lowest priority, top at count-1
  logic [TaskBits-1:0] queued_task [Depth];
  logic [PrioBits-1:0] queued_prio [Depth];
  int                  queued_count = 0;

  // responses still owed by the dut, oldest first
  rsp_t pending_rsp [$];
  int   errors = 0;

  // idle control: sender gaps on/off, receiver stall pattern, hold-off trigger
  int gap_mode   = 0;
  int burst_left = 0;
  int rsp_mode   = 0;
  int hold_token = 0;

  task_priority_ready_queue #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // apply one request to the shadow queue and return the response it gives
  function automatic rsp_t ready_queue_step(input req_t r);
    rsp_t                o;
    int                  pos;
    logic [TaskBits-1:0] top_task;
    logic [PrioBits-1:0] top_prio;
    o = '0;
    o.status = STAT_OK;
    case (action_e'(r.action))
      ACT_PUT: begin
        if (queued_count >= Depth) begin
          // full: the task is dropped
          o.status = STAT_FULL;
        end else begin
          // new task goes below every peer of equal or higher priority
          pos = queued_count;
          while (pos > 0 && queued_prio[pos-1] >= r.priority_req) begin
            queued_task[pos] = queued_task[pos-1];
            queued_prio[pos] = queued_prio[pos-1];
            pos--;
          end
          queued_task[pos] = r.task_id;
          queued_prio[pos] = r.priority_req;
          queued_count++;
        end
      end
      ACT_POP: begin
        if (queued_count == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          queued_count--;
          o.result_task = queued_task[queued_count];
        end
      end
      ACT_PULL: begin
        // the matching entry nearest slot 0 is the one removed
        pos = 0;
        while (pos < queued_count && queued_task[pos] != r.task_id) pos++;
        if (pos >= queued_count) begin
          o.status = STAT_NOT_FOUND;
        end else begin
          queued_count--;
          for (; pos < queued_count; pos++) begin
            queued_task[pos] = queued_task[pos+1];
            queued_prio[pos] = queued_prio[pos+1];
          end
          o.result_task = r.task_id;
        end
      end
      default: begin
        if (queued_count == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          // report the top task and sink it below its equal-priority peers
          pos      = queued_count - 1;
          top_task = queued_task[pos];
          top_prio = queued_prio[pos];
          while (pos > 0 && queued_prio[pos-1] >= top_prio) begin
            queued_task[pos] = queued_task[pos-1];
            queued_prio[pos] = queued_prio[pos-1];
            pos--;
          end
          queued_task[pos] = top_task;
          queued_prio[pos] = top_prio;
          o.result_task    = top_task;
        end
      end
    endcase
    o.count = CountBits'(queued_count);
    return o;
  endfunction

  // offer one request, wait for the handshake, log its expected response;
  // valid stays high into the next request unless a burst gap follows
  task automatic send_req(input action_e act, input logic [TaskBits-1:0] tid,
                          input logic [PrioBits-1:0] prio);
    req_t r;
    r.action       = act;
    r.task_id      = tid;
    r.priority_req = prio;
    in_valid_i <= 1'b1;
    in_i       <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp.push_back(ready_queue_step(r));
    if (gap_mode != 0) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // one random request; the profile sets the action mix
  task automatic send_random(input int unsigned profile, input bit narrow);
    int unsigned         roll;
    action_e             act;
    logic [TaskBits-1:0] tid;
    logic [PrioBits-1:0] prio;
    roll = $urandom_range(0, 99);
    case (profile)
      0: act = roll < 55 ? ACT_PUT : roll < 70 ? ACT_POP : roll < 85 ? ACT_PULL : ACT_NEXT;
      1: act = roll < 25 ? ACT_PUT : roll < 55 ? ACT_POP : roll < 85 ? ACT_PULL : ACT_NEXT;
      2: act = roll < 40 ? ACT_PUT : roll < 60 ? ACT_POP : roll < 80 ? ACT_PULL : ACT_NEXT;
      default: act = roll < 35 ? ACT_PUT : roll < 45 ? ACT_POP : roll < 60 ? ACT_PULL : ACT_NEXT;
    endcase
    // a small id pool now and then makes duplicate entries
    if ($urandom_range(0, 4) == 0) tid = TaskBits'($urandom_range(0, 7));
    else tid = TaskBits'($urandom_range(0, (1 << TaskBits) - 1));
    // most pulls name a task that is actually stored
    if (act == ACT_PULL && queued_count != 0 && $urandom_range(0, 3) != 0) begin
      tid = queued_task[$urandom_range(0, queued_count - 1)];
    end
    // narrow spread piles up equal priorities for fifo and round-robin order
    if (narrow) begin
      if ($urandom_range(0, 1) != 0) prio = PrioBits'($urandom_range(0, 3));
      else prio = PrioBits'($urandom_range(252, 255));
    end else begin
      prio = PrioBits'($urandom_range(0, (1 << PrioBits) - 1));
    end
    send_req(act, tid, prio);
  endtask

  // empty-queue cases, extremes, fifo among equals, rotation, duplicates
  task automatic test_corner_cases();
    send_req(ACT_POP,  7'd127, 8'd255);   // pop on empty
    send_req(ACT_NEXT, 7'd127, 8'd255);   // next on empty
    send_req(ACT_PULL, 7'd127, 8'd0);     // pull on empty
    send_req(ACT_PUT,  7'd0,   8'd0);
    send_req(ACT_PUT,  7'd127, 8'd255);
    send_req(ACT_PUT,  7'd5,   8'd255);   // equal priority lands below
    send_req(ACT_PUT,  7'd127, 8'd10);    // duplicate id
    send_req(ACT_PULL, 7'd127, 8'd0);     // removes the lower duplicate
    send_req(ACT_NEXT, 7'd0,   8'd0);     // rotates among the top peers
    send_req(ACT_NEXT, 7'd0,   8'd0);
    send_req(ACT_NEXT, 7'd0,   8'd0);
    send_req(ACT_PULL, 7'd99,  8'd0);     // not found on a busy queue
    send_req(ACT_PUT,  7'd0,   8'd128);   // duplicate id above the first
    send_req(ACT_PULL, 7'd0,   8'd0);
    send_req(ACT_POP,  7'd0,   8'd0);
    send_req(ACT_POP,  7'd0,   8'd0);
    send_req(ACT_POP,  7'd0,   8'd0);
    send_req(ACT_POP,  7'd0,   8'd0);     // pop on empty again
    send_req(ACT_NEXT, 7'd0,   8'd0);
  endtask

  // fill to full, overflow puts, reopen one slot, then drain past empty
  task automatic test_fill_overflow();
    while (queued_count < Depth) begin
      send_req(ACT_PUT, TaskBits'($urandom_range(0, 127)), PrioBits'($urandom_range(0, 3)));
    end
    repeat (3) send_req(ACT_PUT, TaskBits'($urandom_range(0, 127)), 8'd255);
    send_req(ACT_NEXT, 7'd0, 8'd0);
    send_req(ACT_PULL, queued_task[0], 8'd0);
    send_req(ACT_PUT, 7'd127, 8'd255);
    send_req(ACT_PUT, 7'd1, 8'd0);
    while (queued_count > 0) send_req(ACT_POP, 7'd0, 8'd0);
    send_req(ACT_POP, 7'd0, 8'd0);
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_hold_off();
    gap_mode = 0;
    rsp_mode = 0;
    hold_token++;
    repeat (16) send_random(2, 1'b0);
  endtask

  // random phases with a changing mix and changing idle behavior
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned sent;
    int unsigned phase_len;
    int unsigned profile;
    bit          narrow;
    sent = 0;
    // first phase runs with no idling on either side
    gap_mode = 0;
    rsp_mode = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(60, 150);
      profile   = $urandom_range(0, 3);
      narrow    = (profile == 3) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len && sent < n_items; i++) begin
        send_random(profile, narrow);
        sent++;
      end
      gap_mode = $urandom_range(0, 1);
      rsp_mode = $urandom_range(0, 3);
    end
  endtask

  // receiver stall pattern, plus a counted hold-off when one is triggered
  initial begin : rsp_stall
    int hold_left;
    int hold_seen;
    int phase_cnt;
    hold_left = 0;
    hold_seen = 0;
    phase_cnt = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      phase_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (rsp_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 9) < 7);
          2: out_ready_i <= ((phase_cnt % 7) >= 3);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // response checker
  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $error("response with none pending: task %0d status %0d count %0d",
               out_o.result_task, out_o.status, out_o.count);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_o.result_task !== want.result_task) begin
          $error("result_task mismatch: expected %0d, actual %0d",
                 want.result_task, out_o.result_task);
          errors++;
        end
        if (out_o.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_o.status);
          errors++;
        end
        if (out_o.count !== want.count) begin
          $error("count mismatch: expected %0d, actual %0d", want.count, out_o.count);
          errors++;
        end
      end
    end
  end

  // test sequence
  initial begin : run_tests
    int drain_cnt;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_i       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_corner_cases();
    test_fill_overflow();
    test_output_hold_off();
    test_random_mix(RandomItems);

    // stop offering, let the receiver take everything
    in_valid_i <= 1'b0;
    rsp_mode = 0;
    drain_cnt = 0;
    while (pending_rsp.size() != 0 && drain_cnt < DrainLimit) begin
      @(posedge clk_i);
      drain_cnt++;
    end
    // room for any stray response after the last one
    repeat (Depth + 8) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutNs);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
